>>> rtl/sse_pkg.sv
// Shared types and constants for the sparse set engine.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package sse_pkg;

	localparam int KEY_W  = 10;
	localparam int SLOT_W = 8;
	localparam int CNT_W  = 9;
	localparam int OP_W   = 3;
	localparam int CFG_W  = 10;

	localparam int DEF_KEY_SPACE = 1024;
	localparam int DEF_SLOTS     = 256;

	localparam logic [OP_W-1:0] OP_CONTAINS = 3'd0;
	localparam logic [OP_W-1:0] OP_ADD      = 3'd1;
	localparam logic [OP_W-1:0] OP_REMOVE   = 3'd2;
	localparam logic [OP_W-1:0] OP_CLEAR    = 3'd3;
	localparam logic [OP_W-1:0] OP_READ     = 3'd4;

	localparam logic REG_MAX_KEY    = 1'b0;
	localparam logic REG_SLOT_LIMIT = 1'b1;

	localparam logic [KEY_W-1:0] MAX_KEY_RST    = 10'd1023;
	localparam logic [CNT_W-1:0] SLOT_LIMIT_RST = 9'd256;

	typedef struct packed {
		logic [OP_W-1:0]   opcode;
		logic [KEY_W-1:0]  key;
		logic [SLOT_W-1:0] slot;
	} req_item_t;

	typedef struct packed {
		logic              success;
		logic [KEY_W-1:0]  member;
		logic [CNT_W-1:0]  count;
	} rsp_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAP,
		ST_LIST,
		ST_LAST
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic list_rd;
		logic last_rd;
		logic commit;
		logic rm_commit;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [OP_W-1:0] opcode;
		logic            hit;
		logic            out_free;
		logic            clearing;
	} dp_status_t;

endpackage

`default_nettype wire

>>> rtl/sse_ctrl.sv
// Controller state machine of the sparse set engine.
// Sequences memory reads and commits; depends on sse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sse_ctrl import sse_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_stall,
	input  wire dp_status_t status,
	output ctrl_cmd_t       cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				// No item is taken until the key map has been cleared after reset.
				if (!status.clearing) begin
					req_stall = 1'b0;
					if (req_valid) begin
						cmd.accept = 1'b1;
						state_d    = ST_MAP;
					end
				end
			end
			ST_MAP: begin
				cmd.list_rd = 1'b1;
				state_d     = ST_LIST;
			end
			ST_LIST: begin
				// A successful remove needs the last member, which is one more read.
				if (status.opcode == OP_REMOVE && status.hit) begin
					cmd.last_rd = 1'b1;
					state_d     = ST_LAST;
				end else if (status.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_LAST: begin
				if (status.out_free) begin
					cmd.rm_commit = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/sse_dp.sv
// Datapath of the sparse set engine: item registers, configuration, count,
// the key map and member list memories and the result register. Uses sse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sse_dp import sse_pkg::*; #(
	parameter int KEY_SPACE = DEF_KEY_SPACE,
	parameter int SLOTS     = DEF_SLOTS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire req_item_t        req,
	output rsp_item_t             rsp,
	output logic                  rsp_valid,
	input  wire logic             rsp_stall,
	input  wire logic             cfg_we,
	input  wire logic             cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	input  wire ctrl_cmd_t        cmd,
	output dp_status_t            status
);

	// Keys are ten bits wide and the count nine, so storage beyond that is never reached.
	localparam int MAP_DEPTH  = (KEY_SPACE < 1024) ? KEY_SPACE : 1024;
	localparam int AW         = $clog2(MAP_DEPTH);
	localparam int LIST_DEPTH = (SLOTS < 512) ? SLOTS : 512;
	localparam int SW         = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int SLOTS_CAP  = (SLOTS < 511) ? SLOTS : 511;
	localparam logic [20:0] KEY_LIM = 21'(KEY_SPACE);

	logic [SW-1:0]    map_mem [MAP_DEPTH];
	logic [KEY_W-1:0] list_mem [LIST_DEPTH];

	logic [OP_W-1:0]   op_q;
	logic [KEY_W-1:0]  key_q;
	logic [SLOT_W-1:0] slot_q;
	logic [CNT_W-1:0]  count_q;
	logic [KEY_W-1:0]  max_key_q;
	logic [CNT_W-1:0]  slot_limit_q;
	logic [SW-1:0]     map_rd_q;
	logic [KEY_W-1:0]  list_rd_q;
	rsp_item_t         rsp_q;
	logic              rsp_valid_q;
	logic              clear_busy_q;
	logic [AW-1:0]     clear_addr_q;

	logic             in_range, hit, add_ok, slot_ok, out_free;
	logic [CNT_W-1:0] cap;
	logic             map_we, list_we, list_re;
	logic [AW-1:0]    map_wa;
	logic [SW-1:0]    map_wd, list_wa, list_ra;
	logic [KEY_W-1:0] list_wd;
	rsp_item_t        rsp_d;
	logic [CNT_W-1:0] count_d;

	always_comb begin
		in_range = (key_q <= max_key_q) && (21'(key_q) < KEY_LIM);
		// A stale map entry is harmless: the list must confirm the key.
		hit      = in_range && (9'(map_rd_q) < count_q) && (list_rd_q == key_q);
		cap      = (slot_limit_q < 9'(SLOTS_CAP)) ? slot_limit_q : 9'(SLOTS_CAP);
		add_ok   = in_range && (count_q < cap) && !hit;
		slot_ok  = 9'(slot_q) < count_q;
		out_free = !rsp_valid_q || !rsp_stall;
	end

	always_comb begin
		rsp_d   = '0;
		count_d = count_q;
		map_we  = 1'b0;
		list_we = 1'b0;
		map_wa  = AW'(key_q);
		map_wd  = SW'(count_q);
		list_wa = SW'(count_q);
		list_wd = key_q;
		if (cmd.rm_commit) begin
			// The last member fills the freed slot.
			map_we        = 1'b1;
			list_we       = 1'b1;
			map_wa        = AW'(list_rd_q);
			map_wd        = map_rd_q;
			list_wa       = map_rd_q;
			list_wd       = list_rd_q;
			count_d       = count_q - 9'd1;
			rsp_d.success = 1'b1;
		end else if (cmd.commit) begin
			case (op_q)
				OP_CONTAINS: begin
					rsp_d.success = hit;
				end
				OP_ADD: begin
					if (add_ok) begin
						map_we        = 1'b1;
						list_we       = 1'b1;
						count_d       = count_q + 9'd1;
						rsp_d.success = 1'b1;
					end
				end
				OP_CLEAR: begin
					count_d       = '0;
					rsp_d.success = 1'b1;
				end
				OP_READ: begin
					rsp_d.success = slot_ok;
					rsp_d.member  = slot_ok ? list_rd_q : '0;
				end
				default: begin
				end
			endcase
		end
		rsp_d.count = count_d;
	end

	always_comb begin
		list_re = cmd.list_rd || cmd.last_rd;
		if (cmd.last_rd) begin
			list_ra = SW'(count_q - 9'd1);
		end else if (op_q == OP_READ) begin
			list_ra = SW'(slot_q);
		end else begin
			list_ra = map_rd_q;
		end
	end

	// After reset the key map is zeroed entry by entry before any item is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_busy_q <= 1'b1;
			clear_addr_q <= '0;
		end else if (clear_busy_q) begin
			clear_addr_q <= clear_addr_q + 1'b1;
			if (clear_addr_q == AW'(MAP_DEPTH - 1)) begin
				clear_busy_q <= 1'b0;
			end
		end
	end

	// Single-port key map: cleared after reset, read when an item is taken,
	// written on commit.
	always_ff @(posedge clk) begin
		if (clear_busy_q) begin
			map_mem[clear_addr_q] <= '0;
		end else if (map_we) begin
			map_mem[map_wa] <= map_wd;
		end else if (cmd.accept) begin
			map_rd_q <= map_mem[AW'(req.key)];
		end
	end

	// Single-port member list.
	always_ff @(posedge clk) begin
		if (list_we) begin
			list_mem[list_wa] <= list_wd;
		end else if (list_re) begin
			list_rd_q <= list_mem[list_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= req.opcode;
			key_q  <= req.key;
			slot_q <= req.slot;
		end
		if (cmd.commit || cmd.rm_commit) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			max_key_q    <= MAX_KEY_RST;
			slot_limit_q <= SLOT_LIMIT_RST;
			rsp_valid_q  <= 1'b0;
		end else begin
			count_q <= count_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MAX_KEY:    max_key_q    <= cfg_data;
					REG_SLOT_LIMIT: slot_limit_q <= cfg_data[CNT_W-1:0];
					default: begin
					end
				endcase
			end
			if (cmd.commit || cmd.rm_commit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	assign status.opcode   = op_q;
	assign status.hit      = hit;
	assign status.out_free = out_free;
	assign status.clearing = clear_busy_q;

endmodule

`default_nettype wire

>>> rtl/sparse_set_engine.sv
// Top level of the sparse set engine: joins the controller and the datapath.
// Depends on sse_pkg, sse_ctrl and sse_dp.
`timescale 1ns / 1ps
`default_nettype none

// The engine keeps a sparse set of keys in two single-port memories, a key to
// slot map and a dense member list, and handles one item at a time. Each item
// passes through a map read, a list read and a commit, and a successful remove
// also reads the last member from the list port before its commit. A
// finished result waits in an output register while the next item is taken
// in; the commit waits only if that register is still full and stalled. After
// reset the key map is zeroed entry by entry over the whole map, and the
// input stays stalled until that pass ends. Map entries are always checked
// against the member list, and clear only zeroes the count.

module sparse_set_engine import sse_pkg::*; #(
	parameter int KEY_SPACE = DEF_KEY_SPACE,
	parameter int SLOTS     = DEF_SLOTS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_stall,
	input  wire req_item_t        req,
	output logic                  rsp_valid,
	input  wire logic             rsp_stall,
	output rsp_item_t             rsp,
	input  wire logic             cfg_we,
	input  wire logic             cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	sse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.status    (status),
		.cmd       (cmd)
	);

	sse_dp #(
		.KEY_SPACE (KEY_SPACE),
		.SLOTS     (SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the sparse set engine: a table of directed items,
// then random phases under several register settings, with random idling.
// Depends on sse_pkg and sparse_set_engine.
`timescale 1ns / 1ps

module tb;
	import sse_pkg::*;

	// Opcodes that the block must treat as no operation.
	localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
	localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 3'd7;
	localparam int              N_PHASES        = 6;

	typedef struct packed {
		logic             is_cfg;
		logic             cfg_reg;
		logic [CFG_W-1:0] cfg_val;
		req_item_t        op;
		logic             typed;
		rsp_item_t        want;
	} step_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             req_valid = 1'b0;
	logic             req_stall;
	req_item_t        req       = '0;
	logic             rsp_valid;
	logic             rsp_stall = 1'b0;
	rsp_item_t        rsp;
	logic             cfg_we    = 1'b0;
	logic             cfg_index = REG_MAX_KEY;
	logic [CFG_W-1:0] cfg_data  = '0;

	// Predicted state of the set and of its two registers.
	logic [SLOT_W-1:0] set_map  [DEF_KEY_SPACE];
	logic [KEY_W-1:0]  set_list [DEF_SLOTS];
	logic [CNT_W-1:0]  set_count;
	logic [KEY_W-1:0]  lim_max_key;
	logic [CNT_W-1:0]  lim_slots;

	rsp_item_t pending_rsp [$];
	step_t     dir_steps [$];

	int err_count     = 0;
	int items_sent    = 0;
	int rsp_seen      = 0;
	int cfg_writes    = 0;
	int peak_count    = 0;
	int send_gap_pct  = 0;
	int rcv_stall_pct = 0;

	// Per phase: max_key, slot_limit, add, remove and clear weights, item count.
	int ph_key   [N_PHASES] = '{1023, 63, 0, 1023, 511, 1023};
	int ph_slots [N_PHASES] = '{256, 16, 1, 0, 200, 256};
	int ph_add   [N_PHASES] = '{35, 35, 35, 30, 40, 92};
	int ph_rem   [N_PHASES] = '{20, 25, 25, 20, 20, 2};
	int ph_clr   [N_PHASES] = '{2, 3, 3, 0, 2, 0};
	int ph_items [N_PHASES] = '{80, 90, 40, 40, 80, 330};

	sparse_set_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#(5_000_000);
		$display("Timed out with %0d results outstanding.", pending_rsp.size());
		$display("end of test: mismatches");
		$finish;
	end

	task automatic flag_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		err_count++;
	endtask

	function automatic logic key_ok(input logic [KEY_W-1:0] k);
		return k <= lim_max_key;
	endfunction

	// A key is held only when its map entry points below the count at a list
	// entry that names the key; stale map entries are thereby ignored.
	function automatic logic in_set(input logic [KEY_W-1:0] k);
		return key_ok(k) && (set_map[k] < set_count) && (set_list[set_map[k]] == k);
	endfunction

	function automatic rsp_item_t apply_set_op(input req_item_t it);
		rsp_item_t         res;
		logic [SLOT_W-1:0] pos;
		logic [KEY_W-1:0]  last;
		logic [CNT_W-1:0]  room;
		res  = '0;
		room = (lim_slots < DEF_SLOTS) ? lim_slots : CNT_W'(DEF_SLOTS);
		case (it.opcode)
			OP_CONTAINS: begin
				res.success = in_set(it.key);
			end
			OP_ADD: begin
				if (key_ok(it.key) && set_count < room && !in_set(it.key)) begin
					set_list[set_count[SLOT_W-1:0]] = it.key;
					set_map[it.key] = set_count[SLOT_W-1:0];
					set_count = set_count + 1'b1;
					res.success = 1'b1;
				end
			end
			OP_REMOVE: begin
				if (in_set(it.key) && set_count != 0) begin
					pos = set_map[it.key];
					last = set_list[set_count - 1'b1];
					set_list[pos] = last;
					set_map[last] = pos;
					set_count = set_count - 1'b1;
					res.success = 1'b1;
				end
			end
			OP_CLEAR: begin
				set_count = '0;
				res.success = 1'b1;
			end
			OP_READ: begin
				if (it.slot < set_count) begin
					res.member = set_list[it.slot];
					res.success = 1'b1;
				end
			end
			default: begin
			end
		endcase
		res.count = set_count;
		return res;
	endfunction

	function automatic step_t op_row(input logic [OP_W-1:0] opc, input int k, input int s,
			input logic typed, input logic ok, input int mem, input int cnt);
		step_t r;
		r = '0;
		r.op.opcode = opc;
		r.op.key = KEY_W'(k);
		r.op.slot = SLOT_W'(s);
		r.typed = typed;
		r.want.success = ok;
		r.want.member = KEY_W'(mem);
		r.want.count = CNT_W'(cnt);
		return r;
	endfunction

	function automatic step_t cfg_row(input logic idx, input int val);
		step_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.cfg_reg = idx;
		r.cfg_val = CFG_W'(val);
		return r;
	endfunction

	task automatic run_item(input req_item_t it, input logic typed, input rsp_item_t want);
		rsp_item_t model;
		while ($urandom_range(0, 99) < send_gap_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= it;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		model = apply_set_op(it);
		if (int'(model.count) > peak_count)
			peak_count = int'(model.count);
		pending_rsp.push_back(typed ? want : model);
		items_sent++;
	endtask

	task automatic drain(input int extra);
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
		drain(2);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_MAX_KEY)
			lim_max_key = val[KEY_W-1:0];
		else
			lim_slots = val[CNT_W-1:0];
		cfg_writes++;
	endtask

	function automatic req_item_t draw_item(input int add_w, input int rem_w, input int clr_w);
		req_item_t it;
		int        r;
		int        q;
		r = $urandom_range(0, 99);
		if (r < add_w)
			it.opcode = OP_ADD;
		else if (r < add_w + rem_w)
			it.opcode = OP_REMOVE;
		else if (r < add_w + rem_w + clr_w)
			it.opcode = OP_CLEAR;
		else if (r < add_w + rem_w + clr_w + 3)
			it.opcode = OP_UNUSED_FIRST
				+ OP_W'($urandom_range(0, OP_UNUSED_LAST - OP_UNUSED_FIRST));
		else
			it.opcode = r[0] ? OP_CONTAINS : OP_READ;
		// Adds mostly take random keys so that the set can fill; other items aim at
		// current members more often, though still less than half the time.
		q = $urandom_range(0, 9);
		if (set_count != 0 && (it.opcode == OP_ADD ? q < 1 : q < 4))
			it.key = set_list[$urandom_range(0, set_count - 1)];
		else if (q < 7)
			it.key = KEY_W'($urandom_range(0, lim_max_key));
		else
			it.key = KEY_W'($urandom_range(0, DEF_KEY_SPACE - 1));
		if (set_count != 0 && $urandom_range(0, 1))
			it.slot = SLOT_W'($urandom_range(0, set_count - 1));
		else
			it.slot = SLOT_W'($urandom_range(0, DEF_SLOTS - 1));
		return it;
	endfunction

	always @(posedge clk) begin : rsp_check
		rsp_item_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			rsp_seen++;
			if (pending_rsp.size() == 0) begin
				flag_mismatch($sformatf("result %h arrived with no item outstanding", rsp));
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.success !== want.success)
					flag_mismatch($sformatf("success %b, predicted %b", rsp.success, want.success));
				if (rsp.member !== want.member)
					flag_mismatch($sformatf("member %0d, predicted %0d", rsp.member, want.member));
				if (rsp.count !== want.count)
					flag_mismatch($sformatf("count %0d, predicted %0d", rsp.count, want.count));
			end
		end
		rsp_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
	end

	initial begin : stimulus
		req_item_t it;
		for (int i = 0; i < DEF_KEY_SPACE; i++)
			set_map[i] = '0;
		for (int i = 0; i < DEF_SLOTS; i++)
			set_list[i] = '0;
		set_count = '0;
		lim_max_key = MAX_KEY_RST;
		lim_slots = SLOT_LIMIT_RST;

		// Directed items at the reset settings, then with a narrow key range and
		// a tiny capacity, including a limit lowered below the current count.
		dir_steps.push_back(op_row(OP_CONTAINS, 0, 0, 1, 0, 0, 0));
		dir_steps.push_back(op_row(OP_READ, 0, 0, 1, 0, 0, 0));
		dir_steps.push_back(op_row(OP_REMOVE, 5, 0, 1, 0, 0, 0));
		dir_steps.push_back(op_row(OP_ADD, 0, 0, 1, 1, 0, 1));
		dir_steps.push_back(op_row(OP_ADD, 1023, 255, 1, 1, 0, 2));
		dir_steps.push_back(op_row(OP_ADD, 0, 0, 1, 0, 0, 2));
		dir_steps.push_back(op_row(OP_CONTAINS, 1023, 0, 1, 1, 0, 2));
		dir_steps.push_back(op_row(OP_READ, 0, 1, 1, 1, 1023, 2));
		dir_steps.push_back(op_row(OP_READ, 1023, 255, 1, 0, 0, 2));
		dir_steps.push_back(op_row(OP_REMOVE, 0, 0, 1, 1, 0, 1));
		dir_steps.push_back(op_row(OP_READ, 0, 0, 1, 1, 1023, 1));
		dir_steps.push_back(op_row(OP_UNUSED_FIRST, 1023, 255, 1, 0, 0, 1));
		dir_steps.push_back(op_row(OP_UNUSED_FIRST + 1'b1, 0, 0, 1, 0, 0, 1));
		dir_steps.push_back(op_row(OP_UNUSED_LAST, 'h2AA, 'hAA, 0, 0, 0, 0));
		dir_steps.push_back(op_row(OP_ADD, 'h155, 'h55, 0, 0, 0, 0));
		dir_steps.push_back(op_row(OP_CLEAR, 0, 0, 1, 1, 0, 0));
		dir_steps.push_back(op_row(OP_CONTAINS, 1023, 0, 1, 0, 0, 0));
		dir_steps.push_back(cfg_row(REG_MAX_KEY, 100));
		dir_steps.push_back(cfg_row(REG_SLOT_LIMIT, 2));
		dir_steps.push_back(op_row(OP_ADD, 101, 0, 1, 0, 0, 0));
		dir_steps.push_back(op_row(OP_ADD, 100, 0, 1, 1, 0, 1));
		dir_steps.push_back(op_row(OP_ADD, 0, 0, 1, 1, 0, 2));
		dir_steps.push_back(op_row(OP_ADD, 7, 0, 1, 0, 0, 2));
		dir_steps.push_back(cfg_row(REG_SLOT_LIMIT, 0));
		dir_steps.push_back(op_row(OP_ADD, 8, 0, 1, 0, 0, 2));
		dir_steps.push_back(op_row(OP_REMOVE, 1023, 0, 1, 0, 0, 2));
		dir_steps.push_back(op_row(OP_REMOVE, 100, 0, 0, 0, 0, 0));
		dir_steps.push_back(cfg_row(REG_MAX_KEY, 0));
		dir_steps.push_back(op_row(OP_CONTAINS, 0, 0, 1, 1, 0, 1));
		dir_steps.push_back(op_row(OP_CONTAINS, 1, 0, 1, 0, 0, 1));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_gap_pct = 14;
		rcv_stall_pct = 54;
		foreach (dir_steps[i]) begin
			if (dir_steps[i].is_cfg)
				write_reg(dir_steps[i].cfg_reg, dir_steps[i].cfg_val);
			else
				run_item(dir_steps[i].op, dir_steps[i].typed, dir_steps[i].want);
		end

		for (int p = 0; p < N_PHASES; p++) begin
			if (p < 2) begin
				send_gap_pct = 14;
				rcv_stall_pct = 54;
			end else if (p < 4) begin
				send_gap_pct = 54;
				rcv_stall_pct = 14;
			end else begin
				send_gap_pct = 0;
				rcv_stall_pct = 0;
			end
			write_reg(REG_MAX_KEY, CFG_W'(ph_key[p]));
			write_reg(REG_SLOT_LIMIT, CFG_W'(ph_slots[p]));
			for (int n = 0; n < ph_items[p]; n++) begin
				it = draw_item(ph_add[p], ph_rem[p], ph_clr[p]);
				run_item(it, 1'b0, '0);
			end
		end

		drain(20);
		$display("Sent %0d items (%0d directed rows) over %0d register writes; %0d results checked.",
			items_sent, dir_steps.size(), cfg_writes, rsp_seen);
		$display("Largest set size reached: %0d members.", peak_count);
		if (err_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/sse_pkg.sv
rtl/sse_ctrl.sv
rtl/sse_dp.sv
rtl/sparse_set_engine.sv
tb/tb.sv
